// File: rtl/core/lu_pkg.sv
// ----------------------------------------------------------------------------
// LU package
// Shared types for the LU decomposition controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lu_pkg;

  // Largest matrix dimension the store and the permutation hold.
  localparam int MaxDim = 8;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_A,
    CMD_RD_B,
    CMD_PIV,
    CMD_SWAP_W1,
    CMD_SWAP_W2,
    CMD_DIV_START,
    CMD_DIV_WR,
    CMD_MUL,
    CMD_SUB_WR
  } lu_cmd_e;

  typedef struct packed {
    lu_cmd_e    cmd;
    logic [5:0] addr;
    logic [2:0] row;
    logic       first;
    logic       perm_init;
    logic       perm_swap;
    logic [2:0] perm_a;
    logic [2:0] perm_b;
  } lu_ctrl_t;

  typedef struct packed {
    logic        div_done;
    logic        pivot_zero;
    logic [2:0]  best_row;
    logic [31:0] rdata;
    logic [2:0]  perm_out;
  } lu_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lu_decomposition_partial_pivot_top.sv
// ----------------------------------------------------------------------------
// LU decomposition with partial pivoting, top level
// Loads an n-by-n Q16.16 matrix and returns its L and U factors.
// ----------------------------------------------------------------------------
// The input channel takes one matrix element per transaction in row-major
// order; the matrix size register sets n (0 acts as 1, above 8 acts as 8).
// A write to the register discards a partial load.
// After the last element the input stalls while the block factors the
// matrix with one shared single-port store, one restoring divider and one
// multiplier. Each quotient is read, divided and written back, the pivot
// search reads each remaining row of the column and a row swap exchanges
// the two rows one column at a time.
// Then follow n^2 output transactions in row-major order; the next matrix
// is taken after the last one is accepted.
// A zero pivot ends the run with a single failure transaction.
// A stalled receiver holds the output register and pauses the sequence.
// Reset clears the control state and sets the size to 8.
`default_nettype none

module lu_decomposition_partial_pivot_top
  import lu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] element_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      lu_value_o,
  output logic [2:0]       row_index_o,
  output logic [2:0]       col_index_o,
  output logic [2:0]       source_row_o,
  output logic             status_o,
  output logic             last_of_run_o
);

  lu_ctrl_t ctrl;
  lu_stat_t stat;

  lu_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .lu_value_o, .row_index_o, .col_index_o,
    .source_row_o, .status_o, .last_of_run_o,
    .ctrl_o (ctrl),
    .stat_i (stat)
  );

  lu_datapath u_dp (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .in_data_i (element_value_i),
    .stat_o    (stat)
  );

endmodule

`default_nettype wire

// File: rtl/core/lu_ram.sv
// ----------------------------------------------------------------------------
// LU RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/lu_div.sv
// ----------------------------------------------------------------------------
// LU divider
// Restoring divider computing sat32((a * 2^16) / p), truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [47:0] n_q, n_d;
  logic [32:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic        neg_q, neg_d;
  logic [33:0] trial;
  logic [48:0] qmag;
  logic signed [49:0] qs;

  assign trial = {r_q, n_q[47]} - {2'b00, d_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      n_d    = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), 16'd0};
      d_d    = den_i[31] ? 32'(-den_i) : 32'(den_i);
      r_d    = 33'd0;
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (!trial[33]) begin
        r_d = trial[32:0];
        n_d = {n_q[46:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], n_q[47]};
        n_d = {n_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign qmag   = {1'b0, n_q};
  assign qs     = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_comb begin
    if (qs > 50'sd2147483647) begin
      quo_o = 32'sh7fffffff;
    end else if (qs < -50'sd2147483648) begin
      quo_o = 32'sh80000000;
    end else begin
      quo_o = qs[31:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lu_datapath.sv
// ----------------------------------------------------------------------------
// LU datapath
// Matrix store, permutation, pivot search, divider and multiply-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_datapath
  import lu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lu_ctrl_t    ctrl_i,
  input  wire logic [31:0] in_data_i,
  output lu_stat_t         stat_o
);

  logic        we;
  logic [31:0] wdata, rdata;
  logic [31:0] a_q, b_q, best_mag_q;
  logic [2:0]  best_q;
  logic [31:0] mag;
  logic signed [63:0] prod_q;
  logic signed [63:0] pt;
  logic signed [64:0] diff;
  logic [31:0] sub_res;
  logic [31:0] quo;
  logic        div_done;
  logic [2:0]  perm_q [MaxDim];

  assign mag = rdata[31] ? 32'(-rdata) : rdata;

  always_comb begin
    we    = 1'b0;
    wdata = in_data_i;
    case (ctrl_i.cmd)
      CMD_LOAD:    begin we = 1'b1; wdata = in_data_i; end
      CMD_SWAP_W1: begin we = 1'b1; wdata = a_q; end
      CMD_SWAP_W2: begin we = 1'b1; wdata = b_q; end
      CMD_DIV_WR:  begin we = 1'b1; wdata = quo; end
      CMD_SUB_WR:  begin we = 1'b1; wdata = sub_res; end
      default:     ;
    endcase
  end

  lu_ram #(.Width(32), .Depth(MaxDim * MaxDim)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (ctrl_i.addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  lu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.cmd == CMD_DIV_START),
    .num_i   (rdata),
    .den_i   (b_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign pt   = (prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16);
  assign diff = 65'($signed(a_q)) - 65'(pt);
  assign sub_res = (diff > 65'sd2147483647) ? 32'h7fffffff :
                   (diff < -65'sd2147483648) ? 32'h80000000 : diff[31:0];

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_RD_A: a_q <= rdata;
      CMD_RD_B: b_q <= rdata;
      CMD_MUL:  prod_q <= $signed(a_q) * $signed(b_q);
      default:  ;
    endcase
    if (ctrl_i.cmd == CMD_PIV) begin
      if (ctrl_i.first || best_mag_q < mag) begin
        best_mag_q <= mag;
        best_q     <= ctrl_i.row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxDim; i++) perm_q[i] <= 3'(i);
    end else if (ctrl_i.perm_init) begin
      for (int i = 0; i < MaxDim; i++) perm_q[i] <= 3'(i);
    end else if (ctrl_i.perm_swap) begin
      perm_q[ctrl_i.perm_a] <= perm_q[ctrl_i.perm_b];
      perm_q[ctrl_i.perm_b] <= perm_q[ctrl_i.perm_a];
    end
  end

  assign stat_o.div_done   = div_done;
  assign stat_o.pivot_zero = (best_mag_q == 32'd0);
  assign stat_o.best_row   = best_q;
  assign stat_o.rdata      = rdata;
  assign stat_o.perm_out   = perm_q[ctrl_i.row];

endmodule

`default_nettype wire

// File: rtl/core/lu_ctrl.sv
// ----------------------------------------------------------------------------
// LU controller
// Sequences loading, factorization and output of the matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_ctrl
  import lu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      lu_value_o,
  output logic [2:0]       row_index_o,
  output logic [2:0]       col_index_o,
  output logic [2:0]       source_row_o,
  output logic             status_o,
  output logic             last_of_run_o,
  output lu_ctrl_t         ctrl_o,
  input  wire lu_stat_t    stat_i
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_PIV    = 4'd1;
  localparam logic [3:0] S_PCHK   = 4'd2;
  localparam logic [3:0] S_SWRA   = 4'd3;
  localparam logic [3:0] S_SWRB   = 4'd4;
  localparam logic [3:0] S_SWW    = 4'd5;
  localparam logic [3:0] S_DRP    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_URD    = 4'd8;
  localparam logic [3:0] S_UMUL   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_FAIL   = 4'd11;

  logic [3:0] st_q, st_d;
  logic [3:0] size_q, size_d;
  logic [3:0] n;
  logic [6:0] cnt_q, cnt_d;
  logic [6:0] total;
  logic [2:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [2:0] ph_q, ph_d;
  logic       ov_q, ov_d;
  logic [31:0] val_q, val_d;
  logic [2:0]  ro_q, ro_d, co_q, co_d, so_q, so_d;
  logic [2:0]  orow_q, orow_d, ocol_q, ocol_d;
  logic        stt_q, stt_d, lst_q, lst_d;
  logic [2:0]  nm1;

  assign n     = (size_q == 4'd0) ? 4'd1 : (size_q > 4'(MaxDim)) ? 4'(MaxDim) : size_q;
  assign nm1   = 3'(n - 4'd1);
  assign total = 7'(n * n);

  function automatic logic [5:0] adr(input logic [2:0] r, input logic [2:0] c,
                                     input logic [3:0] nn);
    adr = 6'(r * nn + c);
  endfunction

  assign in_ready_o    = (st_q == S_LOAD) && !ov_q;
  assign out_valid_o   = ov_q;
  assign lu_value_o    = val_q;
  assign row_index_o   = orow_q;
  assign col_index_o   = ocol_q;
  assign source_row_o  = so_q;
  assign status_o      = stt_q;
  assign last_of_run_o = lst_q;

  always_comb begin
    st_d = st_q; size_d = size_q; cnt_d = cnt_q;
    k_d = k_q; i_d = i_q; j_d = j_q; ph_d = ph_q;
    ov_d = ov_q; val_d = val_q; ro_d = ro_q; co_d = co_q; so_d = so_q;
    orow_d = orow_q; ocol_d = ocol_q;
    stt_d = stt_q; lst_d = lst_q;
    ctrl_o = '0;
    ctrl_o.cmd = CMD_NONE;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_LOAD: begin
        if (in_valid_i && in_ready_o) begin
          ctrl_o.cmd  = CMD_LOAD;
          ctrl_o.addr = cnt_q[5:0];
          if (cnt_q + 7'd1 >= total) begin
            cnt_d = 7'd0;
            ctrl_o.perm_init = 1'b1;
            k_d = 3'd0; i_d = 3'd0; ph_d = 3'd0; st_d = S_PIV;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      S_PIV: begin
        // Phase 0 issues the read of row i; phase 1 compares it.
        ctrl_o.addr = adr(i_q, k_q, n);
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
        end else begin
          ctrl_o.cmd = CMD_PIV;
          ctrl_o.row = i_q;
          ctrl_o.first = (i_q == k_q);
          ph_d = 3'd0;
          if (i_q == nm1) st_d = S_PCHK;
          else i_d = i_q + 3'd1;
        end
      end
      S_PCHK: begin
        if (stat_i.pivot_zero) begin
          st_d = S_FAIL;
        end else if (stat_i.best_row != k_q) begin
          ctrl_o.perm_swap = 1'b1;
          ctrl_o.perm_a = k_q;
          ctrl_o.perm_b = stat_i.best_row;
          j_d = 3'd0; ph_d = 3'd0; st_d = S_SWRA;
        end else begin
          ph_d = 3'd0; st_d = S_DRP;
        end
      end
      S_SWRA: begin
        ctrl_o.addr = adr(k_q, j_q, n);
        if (ph_q == 3'd0) ph_d = 3'd1;
        else begin
          ctrl_o.cmd = CMD_RD_B; ph_d = 3'd0; st_d = S_SWRB;
        end
      end
      S_SWRB: begin
        ctrl_o.addr = adr(stat_i.best_row, j_q, n);
        if (ph_q == 3'd0) ph_d = 3'd1;
        else begin
          ctrl_o.cmd = CMD_RD_A; ph_d = 3'd0; st_d = S_SWW;
        end
      end
      S_SWW: begin
        if (ph_q == 3'd0) begin
          ctrl_o.cmd = CMD_SWAP_W1; ctrl_o.addr = adr(k_q, j_q, n); ph_d = 3'd1;
        end else begin
          ctrl_o.cmd = CMD_SWAP_W2;
          ctrl_o.addr = adr(stat_i.best_row, j_q, n);
          ph_d = 3'd0;
          if (j_q == nm1) st_d = S_DRP;
          else begin j_d = j_q + 3'd1; st_d = S_SWRA; end
        end
      end
      S_DRP: begin
        // Load the pivot into the divisor register, then start on row k+1, or begin the output after the last pivot.
        ctrl_o.addr = adr(k_q, k_q, n);
        if (ph_q == 3'd0) ph_d = 3'd1;
        else begin
          ctrl_o.cmd = CMD_RD_B; ph_d = 3'd0;
          if (k_q == nm1) begin
            cnt_d = 7'd0; st_d = S_OUT;
          end else begin
            i_d = k_q + 3'd1; st_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        ctrl_o.addr = adr(i_q, k_q, n);
        unique case (ph_q)
          3'd0: ph_d = 3'd1;
          3'd1: begin ctrl_o.cmd = CMD_DIV_START; ph_d = 3'd2; end
          default: begin
            if (stat_i.div_done) begin
              ctrl_o.cmd = CMD_DIV_WR; ph_d = 3'd0;
              if (i_q == nm1) begin
                i_d = k_q + 3'd1; j_d = k_q + 3'd1; st_d = S_URD;
              end else i_d = i_q + 3'd1;
            end
          end
        endcase
      end
      S_URD: begin
        // a = l(i,k), b = u(k,j), then load a(i,j) for the subtract.
        unique case (ph_q)
          3'd0: begin ctrl_o.addr = adr(i_q, k_q, n); ph_d = 3'd1; end
          3'd1: begin
            ctrl_o.addr = adr(k_q, j_q, n); ctrl_o.cmd = CMD_RD_A; ph_d = 3'd2;
          end
          3'd2: begin
            ctrl_o.addr = adr(i_q, j_q, n); ctrl_o.cmd = CMD_RD_B; ph_d = 3'd3;
          end
          default: begin
            ctrl_o.addr = adr(i_q, j_q, n); ctrl_o.cmd = CMD_MUL; ph_d = 3'd0;
            st_d = S_UMUL;
          end
        endcase
      end
      S_UMUL: begin
        ctrl_o.addr = adr(i_q, j_q, n);
        if (ph_q == 3'd0) begin
          ctrl_o.cmd = CMD_RD_A; ph_d = 3'd1;
        end else begin
          ctrl_o.cmd = CMD_SUB_WR; ph_d = 3'd0; st_d = S_URD;
          if (j_q == nm1) begin
            j_d = k_q + 3'd1;
            if (i_q == nm1) begin
              k_d = k_q + 3'd1; i_d = k_q + 3'd1; st_d = S_PIV;
            end else i_d = i_q + 3'd1;
          end else j_d = j_q + 3'd1;
        end
      end
      S_OUT: begin
        ctrl_o.addr = cnt_q[5:0];
        ctrl_o.row  = ro_d;
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
          ro_d = 3'd0; co_d = 3'd0;
        end else if (!ov_d) begin
          ctrl_o.row = ro_q;
          ov_d = 1'b1; val_d = stat_i.rdata; so_d = stat_i.perm_out;
          orow_d = ro_q; ocol_d = co_q;
          stt_d = 1'b0;
          lst_d = (cnt_q + 7'd1 == total);
          ph_d = 3'd0;
          if (co_q == nm1) begin
            ro_d = ro_q + 3'd1; co_d = 3'd0;
          end else co_d = co_q + 3'd1;
          cnt_d = cnt_q + 7'd1;
          if (cnt_q + 7'd1 == total) begin
            cnt_d = 7'd0; st_d = S_LOAD;
          end
        end
        if (ph_q == 3'd0) begin ro_d = ro_q; co_d = co_q; end
        if (cnt_q == 7'd0 && ph_q == 3'd0) begin ro_d = 3'd0; co_d = 3'd0; end
      end
      S_FAIL: begin
        if (!ov_d) begin
          ov_d = 1'b1; val_d = '0; orow_d = '0; ocol_d = '0; so_d = '0;
          stt_d = 1'b1; lst_d = 1'b1; cnt_d = 7'd0; st_d = S_LOAD;
        end
      end
      default: st_d = S_LOAD;
    endcase
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      cnt_d  = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; size_q <= 4'd8; cnt_q <= '0;
      k_q <= '0; i_q <= '0; j_q <= '0; ph_q <= '0; ov_q <= 1'b0;
      ro_q <= '0; co_q <= '0; orow_q <= '0; ocol_q <= '0;
    end else begin
      st_q <= st_d; size_q <= size_d; cnt_q <= cnt_d;
      k_q <= k_d; i_q <= i_d; j_q <= j_d; ph_q <= ph_d; ov_q <= ov_d;
      ro_q <= ro_d; co_q <= co_d; orow_q <= orow_d; ocol_q <= ocol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; so_q <= so_d; stt_q <= stt_d; lst_q <= lst_d;
  end

endmodule

`default_nettype wire
